// File: rtl/position_pid_with_stop_band_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the position PID block
// Concurrent checks; they compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef POSITION_PID_WITH_STOP_BAND_MACROS_SVH
`define POSITION_PID_WITH_STOP_BAND_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PPID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PPID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared widths, register codes, reset values and types of the position PID.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppid_pkg;

   // field widths
   localparam int CNT_W     = 16;
   localparam int OVF_W     = 8;
   localparam int TGT_W     = 24;
   localparam int ERR_W     = 24;
   localparam int GAIN_W    = 16;
   localparam int DUTY_W    = 9;
   localparam int SUM_W     = 48;
   localparam int CSR_IDX_W = 8;

   localparam int DEFAULT_OVERFLOW_BITS = 8;

   // duty mapping limits
   localparam int SUM_HIGH = 2000;
   localparam int SUM_LOW  = 400;
   localparam int DUTY_MAX = 400;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd256;
   localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;
   localparam logic [GAIN_W-1:0] STOP_RST   = 16'd400;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P         = 8'd0,
      REG_GAIN_I         = 8'd1,
      REG_GAIN_D         = 8'd2,
      REG_STOP_THRESHOLD = 8'd3
   } csr_reg_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [GAIN_W-1:0] stop_threshold;
   } gains_type;

   // loop state carried from one request to the next
   typedef struct packed {
      logic signed [SUM_W-1:0] integral_acc;    // Q40.8
      logic [ERR_W-1:0]        previous_error;  // never negative
      logic [DUTY_W-1:0]       held_duty;
   } loop_state_type;

   typedef struct packed {
      logic [DUTY_W-1:0]       duty_cycle;
      logic                    loop_active;
      logic signed [SUM_W-1:0] control_sum;
   } result_type;

endpackage

// File: rtl/ppid_if.sv
// ----------------------------------------------------------------------------
// ppid channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppid_req_if;
   logic                         valid;
   logic                         ready;
   logic [ppid_pkg::CNT_W-1:0]   encoder_count;
   logic [ppid_pkg::OVF_W-1:0]   overflow_count;
   logic [ppid_pkg::TGT_W-1:0]   target_position;

   modport source (output valid, encoder_count, overflow_count, target_position,
                   input ready);
   modport sink   (input valid, encoder_count, overflow_count, target_position,
                   output ready);
endinterface

interface ppid_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ppid_pkg::DUTY_W-1:0]    duty_cycle;
   logic                           loop_active;
   logic signed [ppid_pkg::SUM_W-1:0] control_sum;

   modport source (output valid, duty_cycle, loop_active, control_sum,
                   input ready);
   modport sink   (input valid, duty_cycle, loop_active, control_sum,
                   output ready);
endinterface

interface ppid_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ppid_pkg::CSR_IDX_W-1:0]  index;
   logic [ppid_pkg::GAIN_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/position_pid_with_stop_band.sv
// ----------------------------------------------------------------------------
// position_pid_with_stop_band
// Position PID with trapezoid integrator and stop band driving a PWM duty.
//
//   channel  dir  handshake      contents
//   req_ch   in   valid/ready    encoder_count, overflow_count, target_position
//   rsp_ch   out  valid/ready    duty_cycle, loop_active, control_sum
//   csr_ch   in   valid/ready    index, wdata (gains, stop threshold)
//
// A request reaches the response through an input register, then the
// PID step (three multipliers and the integrator add) into the result
// register. One request per cycle is sustained unless rsp_ch stalls; the
// loop state updates as a request moves into the result register. Reset is
// synchronous; it clears the loop state and loads register defaults. A stalled
// response holds the result register and backs up into the input register
// and then req_ch. csr_ch is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "position_pid_with_stop_band_macros.svh"

module position_pid_with_stop_band #(
   parameter int OVERFLOW_BITS = ppid_pkg::DEFAULT_OVERFLOW_BITS
) (
   input  logic       clock,
   input  logic       reset,
   ppid_req_if.sink   req_ch,
   ppid_rsp_if.source rsp_ch,
   ppid_csr_if.sink   csr_ch
);

   logic                              in_valid_ff;
   logic [ppid_pkg::CNT_W-1:0]        cnt_ff;
   logic [ppid_pkg::OVF_W-1:0]        ovf_ff;
   logic [ppid_pkg::TGT_W-1:0]        tgt_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   ppid_pkg::result_type              out_ff;
   ppid_pkg::gains_type               gains_ff;
   ppid_pkg::gains_type               gains_in;
   ppid_pkg::loop_state_type          state_ff;
   ppid_pkg::loop_state_type          state_in;
   ppid_pkg::result_type              step_result;
   logic                              out_free;
   logic                              advance;
   logic                              req_take;

   // pipeline flow
   always_comb begin
      out_free     = !out_valid_ff || rsp_ch.ready;
      advance      = in_valid_ff && out_free;
      req_take     = req_ch.valid && req_ch.ready;
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_take) begin
         cnt_ff <= req_ch.encoder_count;
         ovf_ff <= req_ch.overflow_count;
         tgt_ff <= req_ch.target_position;
      end
   end

   // PID step
   ppid_core #(
      .OVERFLOW_BITS (OVERFLOW_BITS)
   ) u_core (
      .encoder_count   (cnt_ff),
      .overflow_count  (ovf_ff),
      .target_position (tgt_ff),
      .gains           (gains_ff),
      .state           (state_ff),
      .result          (step_result),
      .state_next      (state_in)
   );

   // result register and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.duty_cycle  = out_ff.duty_cycle;
   assign rsp_ch.loop_active = out_ff.loop_active;
   assign rsp_ch.control_sum = out_ff.control_sum;

   // register writes; unknown indexes are dropped
   always_comb begin
      gains_in = gains_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ppid_pkg::REG_GAIN_P:         gains_in.gain_p         = csr_ch.wdata;
            ppid_pkg::REG_GAIN_I:         gains_in.gain_i         = csr_ch.wdata;
            ppid_pkg::REG_GAIN_D:         gains_in.gain_d         = csr_ch.wdata;
            ppid_pkg::REG_STOP_THRESHOLD: gains_in.stop_threshold = csr_ch.wdata;
            default:                      gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.gain_p         <= ppid_pkg::GAIN_P_RST;
         gains_ff.gain_i         <= ppid_pkg::GAIN_I_RST;
         gains_ff.gain_d         <= ppid_pkg::GAIN_D_RST;
         gains_ff.stop_threshold <= ppid_pkg::STOP_RST;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // checks
   `PPID_ASSERT_NEXT(a_idle_step_keeps_state, clock, reset, advance && !step_result.loop_active, $stable(state_ff), "loop state changed on an inactive sample")
   `PPID_ASSERT_IMPLY(a_duty_in_range, clock, reset, out_valid_ff, out_ff.duty_cycle <= ppid_pkg::DUTY_W'(ppid_pkg::DUTY_MAX), "duty above maximum")
   `PPID_ASSERT_IMPLY(a_high_sum_full_duty, clock, reset, out_valid_ff && out_ff.loop_active && (out_ff.control_sum > ppid_pkg::SUM_W'(ppid_pkg::SUM_HIGH)), out_ff.duty_cycle == ppid_pkg::DUTY_W'(ppid_pkg::DUTY_MAX), "large sum did not give full duty")
   `PPID_ASSERT_IMPLY(a_inactive_zero_sum, clock, reset, out_valid_ff && !out_ff.loop_active, out_ff.control_sum == '0, "inactive response carries a sum")

endmodule

// File: rtl/ppid_core.sv
// ----------------------------------------------------------------------------
// ppid_core
// One PID step: position, error, P/I/D terms, integrator saturation and
// the duty mapping with the stop band. Purely combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppid_core #(
   parameter int OVERFLOW_BITS = ppid_pkg::DEFAULT_OVERFLOW_BITS
) (
   input  logic [ppid_pkg::CNT_W-1:0]  encoder_count,
   input  logic [ppid_pkg::OVF_W-1:0]  overflow_count,
   input  logic [ppid_pkg::TGT_W-1:0]  target_position,
   input  ppid_pkg::gains_type         gains,
   input  ppid_pkg::loop_state_type    state,
   output ppid_pkg::result_type        result,
   output ppid_pkg::loop_state_type    state_next
);

   // overflow bits that count, and the widths that follow from them
   localparam int OVF_USED = (OVERFLOW_BITS < ppid_pkg::OVF_W) ?
                             OVERFLOW_BITS : ppid_pkg::OVF_W;
   localparam int POS_W    = ppid_pkg::CNT_W + OVF_USED + 1;
   localparam int CMP_W    = ppid_pkg::TGT_W + 1;
   localparam int ERR_W    = ppid_pkg::ERR_W;
   localparam int GAIN_W   = ppid_pkg::GAIN_W;
   localparam int SUM_W    = ppid_pkg::SUM_W;
   localparam int P_W      = GAIN_W + ERR_W;        // unsigned
   localparam int I_W      = GAIN_W + ERR_W + 1;    // unsigned
   localparam int D_W      = GAIN_W + ERR_W + 2;    // signed
   localparam int ACC_X_W  = SUM_W + 1;
   localparam int TOT_W    = SUM_W + 2;
   localparam int INT_W    = TOT_W - 8;
   localparam int DUTY_W   = ppid_pkg::DUTY_W;

   logic [OVF_USED-1:0]        ovf_used;
   logic [POS_W-1:0]           position;
   logic                       active;
   logic [ERR_W-1:0]           err;
   logic [ERR_W:0]             err_sum;
   logic signed [ERR_W:0]      err_diff;
   logic [P_W-1:0]             p_term;
   logic [I_W-1:0]             i_term;
   logic signed [D_W-1:0]      d_term;
   logic signed [ACC_X_W-1:0]  acc_raw;
   logic signed [SUM_W-1:0]    acc_sat;
   logic signed [TOT_W-1:0]    total;
   logic signed [TOT_W-1:0]    total_adj;
   logic signed [INT_W-1:0]    sum_int;
   logic [DUTY_W-1:0]          duty;

   // position = count + 65535 * overflow, done as a shift and subtract
   always_comb begin
      ovf_used = overflow_count[OVF_USED-1:0];
      position = POS_W'({ovf_used, 16'h0000}) - POS_W'(ovf_used)
               + POS_W'(encoder_count);
      active   = CMP_W'(position) < CMP_W'(target_position);
      err      = target_position - ERR_W'(position);
   end

   // the three gain products
   always_comb begin
      err_sum  = {1'b0, err} + {1'b0, state.previous_error};
      err_diff = $signed({1'b0, err}) - $signed({1'b0, state.previous_error});
      p_term   = gains.gain_p * err;
      i_term   = gains.gain_i * err_sum;
      d_term   = $signed({1'b0, gains.gain_d}) * err_diff;
   end

   // integrator; the increment is never negative so only the top can clip
   always_comb begin
      acc_raw = ACC_X_W'(state.integral_acc) + $signed(ACC_X_W'(i_term));
      if (acc_raw[ACC_X_W-1] != acc_raw[ACC_X_W-2]) begin
         acc_sat = acc_raw[ACC_X_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         acc_sat = acc_raw[SUM_W-1:0];
      end
   end

   // P + I + D, integer part truncated toward zero
   always_comb begin
      total     = TOT_W'(acc_sat) + $signed(TOT_W'(p_term)) + TOT_W'(d_term);
      total_adj = total[TOT_W-1] ? total + TOT_W'(255) : total;
      sum_int   = total_adj[TOT_W-1:8];
   end

   // duty mapping; the middle band keeps the previous duty
   always_comb begin
      duty = state.held_duty;
      if (sum_int > INT_W'(ppid_pkg::SUM_HIGH)) begin
         duty = DUTY_W'(ppid_pkg::DUTY_MAX);
      end else if (sum_int < INT_W'(ppid_pkg::SUM_LOW)) begin
         if (sum_int[INT_W-1] || (err < gains.stop_threshold)) begin
            duty = '0;
         end else begin
            duty = sum_int[DUTY_W-1:0];
         end
      end
   end

   // results and next state; nothing moves when at or past target
   always_comb begin
      state_next = state;
      result.duty_cycle  = state.held_duty;
      result.loop_active = 1'b0;
      result.control_sum = '0;
      if (active) begin
         state_next.integral_acc   = acc_sat;
         state_next.previous_error = err;
         state_next.held_duty      = duty;
         result.duty_cycle  = duty;
         result.loop_active = 1'b1;
         result.control_sum = SUM_W'(sum_int);
      end
   end

endmodule
